// ===== rtl/core/fue_pkg.sv =====
package fue_pkg;

  localparam logic [2:0] KIND_BODY       = 3'd0;
  localparam logic [2:0] KIND_FIELD      = 3'd1;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd2;
  localparam logic [2:0] KIND_NAME_END   = 3'd3;
  localparam logic [2:0] KIND_VALUE_BYTE = 3'd4;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CHAR_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;  // '='
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;

  // Up to three characters produced by one item, lowest index goes out first.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            err;
    logic [2:0][7:0] chars;
  } enc_res_t;

  function automatic logic is_unreserved(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h61) && (c <= 8'h7A)) ||
        ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h30) && (c <= 8'h39)) ||
        (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h7E);
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h41 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fue_encoder.sv =====
module fue_encoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [2:0]       kind_i,
  input  logic [7:0]       in_byte_i,
  input  logic [15:0]      capacity_i,
  output fue_pkg::enc_res_t res_o
);
  import fue_pkg::*;

  logic [15:0] len_q, len_d;
  logic        first_q, first_d;
  logic        failed_q, failed_d;

  logic            want;
  logic [1:0]      n;
  logic [2:0][7:0] chars;
  logic            fit;

  always_comb begin
    want  = 1'b0;
    n     = 2'd0;
    chars = '0;
    if (!failed_q) begin
      case (kind_i) inside
        KIND_FIELD: begin
          if (!first_q) begin
            want     = 1'b1;
            n        = 2'd1;
            chars[0] = CHAR_AMP;
          end
        end
        KIND_NAME_END: begin
          want     = 1'b1;
          n        = 2'd1;
          chars[0] = CHAR_EQUALS;
        end
        KIND_NAME_BYTE, KIND_VALUE_BYTE: begin
          want = 1'b1;
          if (is_unreserved(in_byte_i)) begin
            n        = 2'd1;
            chars[0] = in_byte_i;
          end else if (in_byte_i == CHAR_SPACE) begin
            n        = 2'd1;
            chars[0] = CHAR_PLUS;
          end else begin
            n        = 2'd3;
            chars[0] = CHAR_PERCENT;
            chars[1] = hex_digit(in_byte_i[7:4]);
            chars[2] = hex_digit(in_byte_i[3:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // A write fits only while one slot stays free for the terminator
  assign fit = (({1'b0, len_q} + {15'd0, n}) < {1'b0, capacity_i});

  always_comb begin
    res_o = '0;
    if (want) begin
      if (fit) begin
        res_o.cnt   = n;
        res_o.chars = chars;
      end else begin
        res_o.cnt = 2'd1;
        res_o.err = 1'b1;
      end
    end
  end

  always_comb begin
    len_d    = len_q;
    first_d  = first_q;
    failed_d = failed_q;
    if (adv_i) begin
      if (kind_i == KIND_BODY) begin
        len_d    = '0;
        first_d  = 1'b1;
        failed_d = 1'b0;
      end else if (!failed_q) begin
        if (kind_i == KIND_FIELD) begin
          first_d = 1'b0;
        end
        if (want && fit) begin
          len_d = len_q + {14'd0, n};
        end else if (want) begin
          failed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      first_q  <= 1'b1;
      failed_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      first_q  <= first_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ===== rtl/core/fue_out_buf.sv =====
module fue_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fue_pkg::enc_res_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              last_o,
  output logic              error_o
);
  import fue_pkg::*;

  logic [1:0]      rem_q, rem_d;
  logic [2:0][7:0] ch_q, ch_d;
  logic            err_q, err_d;
  logic            pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // Free for the next item once the last character of this one leaves
  assign free_o      = (rem_q == 2'd0) || ((rem_q == 2'd1) && pop);
  assign out_char_o  = ch_q[0];
  assign last_o      = (rem_q == 2'd1);
  assign error_o     = err_q;

  always_comb begin
    rem_d = rem_q;
    ch_d  = ch_q;
    err_d = err_q;
    if (load_i) begin
      rem_d = res_i.cnt;
      ch_d  = res_i.chars;
      err_d = res_i.err;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      ch_d  = {8'd0, ch_q[2], ch_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q  <= ch_d;
    err_q <= err_d;
  end

endmodule

// ===== rtl/core/form_urlencoded_body_encoder.sv =====
// Form-urlencoded body encoder.
// Input channel (in_valid_i/in_ready_o) carries items: kind_i selects body
// start, field start, name byte, name end or value byte; in_byte_i is the raw
// byte for byte items. Output channel (out_valid_o/out_ready_i) carries one
// encoded character per transfer; last_o marks the final character of an
// item, error_o marks the single overflow result after which the body is
// dropped until the next body start.
// body_capacity_i is written when cfg_we_i is high; write it only when idle.
// An accepted item is held in the input register, encoded combinationally
// and loaded into the output register; its first character leaves from there.
// Throughput: one item per cycle for items that give one character or none,
// while the receiver is ready; an escaped byte gives three characters that
// leave the output register one by one, and the next item waits for them.
// Reset clears the body state (length zero, first field pending, not failed),
// empties the pipeline and sets the capacity to 1024.
// When the receiver stalls, the current character holds and, once the input
// register is occupied, in_ready_o drops; nothing is lost.
module form_urlencoded_body_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o,
  output logic        error_o,
  input  logic        cfg_we_i,
  input  logic [15:0] body_capacity_i
);
  import fue_pkg::*;

  logic        vld_q;
  logic [2:0]  kind_q;
  logic [7:0]  byte_q;
  logic [15:0] cap_q;
  logic        free;
  logic        adv;
  enc_res_t    res;

  assign adv        = vld_q && free;
  assign in_ready_o = !vld_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cap_q <= CAPACITY_RESET;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (cfg_we_i) begin
        cap_q <= body_capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      byte_q <= in_byte_i;
    end
  end

  fue_encoder u_enc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .kind_i     (kind_q),
    .in_byte_i  (byte_q),
    .capacity_i (cap_q),
    .res_o      (res)
  );

  fue_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && (res.cnt != 2'd0)),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

// ===== rtl/core/fue_checker.sv =====
module fue_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_char_o,
  input logic        last_o,
  input logic        error_o
);

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) &&
    $stable(last_o) && $stable(error_o))
    else $error("output item changed while stalled");

  // Overflow is a single-result item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (out_char_o == 8'd0))
    else $error("error item is not a lone zero character");

  // The rest of an escape follows without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && !error_o)
    else $error("gap inside a multi-character item");

  // The character after a percent sign is an upper-case hex digit
  a_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o && (out_char_o == 8'h25) |=>
    ((out_char_o >= 8'h30) && (out_char_o <= 8'h39)) ||
    ((out_char_o >= 8'h41) && (out_char_o <= 8'h46)))
    else $error("escape digit is not upper-case hex");

endmodule

bind form_urlencoded_body_encoder fue_checker u_fue_checker (.*);

// ===== sim/fue_body_checker.sv =====
`timescale 1ns / 100ps

module fue_body_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic        last_i,
  input  logic        error_i,
  input  logic        cfg_we_i,
  input  logic [15:0] body_capacity_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  import fue_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } body_char_t;

  body_char_t  pending_chars[$];
  logic [15:0] capacity;
  logic [15:0] body_len;
  logic        first_field;
  logic        body_failed;
  int          mismatches = 0;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

  // letters, digits and - _ . ~ go out as they are
  function automatic logic keeps_literal(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) r = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) r = 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) r = 1'b1;
    if (c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h7E) r = 1'b1;
    return r;
  endfunction

  function automatic void put_chars(input logic [7:0] c0, input logic [7:0] c1,
                                    input logic [7:0] c2, input int n);
    logic [7:0] seq [3];
    int k;
    seq[0] = c0;
    seq[1] = c1;
    seq[2] = c2;
    // one slot is kept for the terminator, hence >=
    if (int'(body_len) + n >= int'(capacity)) begin
      pending_chars.push_back({8'h00, 1'b1, 1'b1});
      body_failed = 1'b1;
    end else begin
      for (k = 0; k < n; k++) begin
        pending_chars.push_back({seq[k], (k == n - 1), 1'b0});
      end
      body_len = body_len + n[15:0];
    end
  endfunction

  function automatic void encode_item(input logic [2:0] kind, input logic [7:0] b);
    if (kind == KIND_BODY) begin
      body_len = 16'd0;
      first_field = 1'b1;
      body_failed = 1'b0;
    end else if (!body_failed) begin
      case (kind)
        KIND_FIELD: begin
          if (first_field) begin
            first_field = 1'b0;
          end else begin
            put_chars(CHAR_AMP, 8'h00, 8'h00, 1);
          end
        end
        KIND_NAME_END: begin
          put_chars(CHAR_EQUALS, 8'h00, 8'h00, 1);
        end
        KIND_NAME_BYTE, KIND_VALUE_BYTE: begin
          if (keeps_literal(b)) begin
            put_chars(b, 8'h00, 8'h00, 1);
          end else if (b == CHAR_SPACE) begin
            put_chars(CHAR_PLUS, 8'h00, 8'h00, 1);
          end else begin
            put_chars(CHAR_PERCENT, hex_char(b[7:4]), hex_char(b[3:0]), 3);
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    body_char_t want;
    if (!rst_ni) begin
      capacity = CAPACITY_RESET;
      body_len = 16'd0;
      first_field = 1'b1;
      body_failed = 1'b0;
      pending_chars.delete();
    end else begin
      if (cfg_we_i) begin
        capacity = body_capacity_i;
      end
      // compare before predicting: an item taken now cannot answer at this edge
      if (out_valid_i && out_ready_i) begin
        if (pending_chars.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected char %02h last %b err %b, nothing pending",
                     $time, out_char_i, last_i, error_i);
          end
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (want != {out_char_i, last_i, error_i}) begin
            if (mismatches < 10) begin
              $display("%0t: char mismatch: expected %02h last %b err %b, got %02h last %b err %b",
                       $time, want.ch, want.last, want.err, out_char_i, last_i, error_i);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        encode_item(kind_i, in_byte_i);
      end
    end
    pending_count_o <= pending_chars.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ===== sim/form_urlencoded_body_encoder_test.sv =====
`timescale 1ns / 100ps

module form_urlencoded_body_encoder_test;

  import fue_pkg::*;

  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 50;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  kind_i;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_char_o;
  logic        last_o;
  logic        error_o;
  logic        cfg_we_i;
  logic [15:0] body_capacity_i;

  int   mismatch_count;
  int   pending_count;
  int   items_sent;
  int   idle_cycles;
  logic idling;
  logic hold_req;

  form_urlencoded_body_encoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o),
    .error_o        (error_o),
    .cfg_we_i       (cfg_we_i),
    .body_capacity_i(body_capacity_i)
  );

  fue_body_checker body_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .kind_i          (kind_i),
    .in_byte_i       (in_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_i      (out_char_o),
    .last_i          (last_o),
    .error_i         (error_o),
    .cfg_we_i        (cfg_we_i),
    .body_capacity_i (body_capacity_i),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input logic [2:0] k, input logic [7:0] b);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    in_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    // items with no output may still be in flight
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    cfg_we_i <= 1'b1;
    body_capacity_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] r;
    case ($urandom_range(0, 6))
      0: r = 8'h61 + 8'($urandom_range(0, 25));
      1: r = 8'h41 + 8'($urandom_range(0, 25));
      2: r = 8'h30 + 8'($urandom_range(0, 9));
      3: begin
        case ($urandom_range(0, 3))
          0: r = 8'h2D;
          1: r = 8'h5F;
          2: r = 8'h2E;
          default: r = 8'h7E;
        endcase
      end
      4: r = CHAR_SPACE;
      5: begin
        // just outside the literal ranges
        case ($urandom_range(0, 5))
          0: r = 8'h2F;
          1: r = 8'h3A;
          2: r = 8'h40;
          3: r = 8'h5B;
          4: r = 8'h60;
          default: r = 8'h7B;
        endcase
      end
      default: r = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_body();
    int nfields;
    int f;
    nfields = $urandom_range(1, 4);
    send_item(KIND_BODY, 8'($urandom_range(0, 255)));
    for (f = 0; f < nfields; f++) begin
      maybe_noise();
      send_item(KIND_FIELD, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 6)) send_item(KIND_NAME_BYTE, pick_byte());
      maybe_noise();
      // now and then the name end goes missing
      if ($urandom_range(0, 9) != 0) begin
        send_item(KIND_NAME_END, 8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 8)) send_item(KIND_VALUE_BYTE, pick_byte());
    end
  endtask

  initial begin
    int p;
    int phase_end;
    logic [15:0] cap;
    logic held;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_BODY;
    in_byte_i = 8'h00;
    cfg_we_i = 1'b0;
    body_capacity_i = CAPACITY_RESET;
    idling = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    held = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset capacity, every class of byte and kind
    send_item(KIND_BODY, 8'hFF);
    send_item(KIND_FIELD, 8'h00);
    send_item(KIND_NAME_BYTE, 8'h61);
    send_item(KIND_NAME_BYTE, 8'h7A);
    send_item(KIND_NAME_BYTE, 8'h41);
    send_item(KIND_NAME_BYTE, 8'h5A);
    send_item(KIND_NAME_BYTE, 8'h30);
    send_item(KIND_NAME_BYTE, 8'h39);
    send_item(KIND_NAME_BYTE, 8'h2D);
    send_item(KIND_NAME_BYTE, 8'h5F);
    send_item(KIND_NAME_BYTE, 8'h2E);
    send_item(KIND_NAME_BYTE, 8'h7E);
    send_item(KIND_NAME_BYTE, CHAR_SPACE);
    send_item(KIND_NAME_BYTE, 8'h00);
    send_item(KIND_NAME_BYTE, 8'hFF);
    send_item(KIND_NAME_END, 8'hAA);
    send_item(KIND_VALUE_BYTE, 8'h7F);
    send_item(KIND_VALUE_BYTE, 8'h80);
    send_item(KIND_VALUE_BYTE, 8'h3A);
    send_item(KIND_FIELD, 8'h55);
    send_item(KIND_NAME_END, 8'h00);
    send_item(3'd5, 8'h41);
    send_item(3'd6, 8'h20);
    send_item(3'd7, 8'hFF);
    send_item(KIND_VALUE_BYTE, CHAR_SPACE);

    // overflow, then everything ignored until the next body start
    wait_drained();
    write_capacity(16'd4);
    send_item(KIND_BODY, 8'h00);
    send_item(KIND_VALUE_BYTE, 8'h25);
    send_item(KIND_VALUE_BYTE, 8'h61);
    send_item(KIND_VALUE_BYTE, 8'h62);
    send_item(KIND_FIELD, 8'h00);
    send_item(KIND_BODY, 8'h00);
    send_item(KIND_NAME_BYTE, 8'h71);

    // zero capacity
    wait_drained();
    write_capacity(16'd0);
    send_item(KIND_NAME_END, 8'h00);
    send_item(KIND_BODY, 8'h00);
    send_item(KIND_FIELD, 8'h00);
    send_item(KIND_NAME_END, 8'h00);
    send_item(KIND_BODY, 8'h00);

    // capacity lowered in the middle of a body
    wait_drained();
    write_capacity(CAPACITY_RESET);
    send_item(KIND_BODY, 8'h00);
    send_item(KIND_VALUE_BYTE, 8'h61);
    send_item(KIND_VALUE_BYTE, 8'h62);
    send_item(KIND_VALUE_BYTE, 8'h63);
    wait_drained();
    write_capacity(16'd2);
    send_item(KIND_VALUE_BYTE, 8'h64);
    send_item(KIND_BODY, 8'h00);

    for (p = 0; p < 6; p++) begin
      case (p)
        0: cap = 16'hFFFF;
        1: cap = 16'd40;
        2: cap = CAPACITY_RESET;
        3: cap = 16'd12;
        4: cap = 16'd1;
        default: cap = 16'($urandom_range(20, 300));
      endcase
      wait_drained();
      write_capacity(cap);
      idling = (p < 5);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        send_random_body();
        if (p == 2 && !held) begin
          // output stalls for a long time while items keep coming
          held = 1'b1;
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          hold_req = 1'b1;
          @(negedge clk_i);
        end
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== form_urlencoded_body_encoder.f =====
rtl/core/fue_pkg.sv
rtl/core/fue_encoder.sv
rtl/core/fue_out_buf.sv
rtl/core/form_urlencoded_body_encoder.sv
rtl/core/fue_checker.sv
sim/fue_body_checker.sv
sim/form_urlencoded_body_encoder_test.sv
